[hw/rtl/line_start_table_lookup_macros.svh]
// Assertion macros for the line start table lookup checker.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef LINE_START_TABLE_LOOKUP_MACROS_SVH
`define LINE_START_TABLE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define LST_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define LST_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lst_pkg.sv]
// Shared types and codes for the line start table lookup.
// No dependencies.
package lst_pkg;

    localparam int DEF_TABLE_DEPTH  = 4096;
    localparam int DEF_OFFSET_WIDTH = 32;
    localparam int CFG_W            = 32;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [CFG_W-1:0] CFG_MAX_RESET = {CFG_W{1'b1}};

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_LINE   = 2'd2;
    localparam logic [1:0] OP_VIRT   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_BAD_LINE = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       skip;
        logic [1:0] status;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

[hw/rtl/lst_front.sv]
// Front end: accepts input words, holds the offset limit register and
// classifies lookups before they are queued. Depends on lst_pkg.
module lst_front #(
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_operation,
    input  logic [OFFSET_WIDTH-1:0] i_begin_index,
    input  logic [OFFSET_WIDTH-1:0] i_end_index,
    input  logic                    i_cfg_we,
    input  logic [lst_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                    i_q_full,
    output logic                    o_push,
    output lst_pkg::t_ctl           o_ctl
);
    import lst_pkg::*;

    localparam int CMP_W = (OFFSET_WIDTH > CFG_W) ? OFFSET_WIDTH : CFG_W;

    logic [CFG_W-1:0] r_max_index;
    logic             no_loc;
    logic             too_large;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_index <= CFG_MAX_RESET;
        end else if (i_cfg_we) begin
            r_max_index <= i_cfg_wdata;
        end
    end

    assign no_loc    = (i_begin_index == '0) && (i_end_index == '0);
    assign too_large = (CMP_W'(i_begin_index) > CMP_W'(r_max_index))
                    || (CMP_W'(i_end_index) > CMP_W'(r_max_index));

    always_comb begin
        o_ctl.op     = i_operation;
        o_ctl.skip   = no_loc || too_large;
        o_ctl.status = (too_large && !no_loc) ? ST_RANGE : ST_OK;
    end

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

[hw/rtl/lst_queue.sv]
// Short queue between front and back end.
// Depends on lst_pkg for its default depth.
module lst_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lst_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_word,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_word
);
    import lst_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_word;
        end
    end

endmodule

[hw/rtl/lst_back.sv]
// Back end: owns the line start memory and the entry count, runs the two
// upper-bound searches and the queries, and drives the output register.
// Depends on lst_pkg.
module lst_back #(
    parameter int TABLE_DEPTH  = 4096,
    parameter int OFFSET_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  lst_pkg::t_ctl                   i_ctl,
    input  logic [OFFSET_WIDTH-1:0]         i_start_index,
    input  logic [OFFSET_WIDTH-1:0]         i_begin_index,
    input  logic [OFFSET_WIDTH-1:0]         i_end_index,
    input  logic [$clog2(TABLE_DEPTH):0]    i_line_number,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [$clog2(TABLE_DEPTH):0]    o_begin_line,
    output logic [$clog2(TABLE_DEPTH):0]    o_end_line,
    output logic [OFFSET_WIDTH:0]           o_begin_column,
    output logic [OFFSET_WIDTH-1:0]         o_line_start,
    output logic                            o_is_virtual,
    output logic [1:0]                      o_status
);
    import lst_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int LINE_W = IDX_W + 1;
    localparam int COL_W  = OFFSET_WIDTH + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRD  = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_CWT  = 3'd3;
    localparam logic [2:0] S_LWT  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [OFFSET_WIDTH-1:0] r_mem [TABLE_DEPTH];
    logic [OFFSET_WIDTH-1:0] r_rdata;
    logic                    r_rzero;

    logic [2:0]              r_state, n_state;
    logic [LINE_W-1:0]       r_count, n_count;
    logic [LINE_W-1:0]       r_lo, n_lo;
    logic [LINE_W-1:0]       r_hi, n_hi;
    logic [IDX_W-1:0]        r_mid, n_mid;
    logic                    r_phase, n_phase;
    logic [LINE_W-1:0]       r_b, n_b;
    logic [OFFSET_WIDTH-1:0] r_x, n_x;
    logic [OFFSET_WIDTH-1:0] r_beg, n_beg;
    logic [OFFSET_WIDTH-1:0] r_end, n_end;

    logic [LINE_W-1:0]       r_res_bl, n_res_bl;
    logic [LINE_W-1:0]       r_res_el, n_res_el;
    logic [COL_W-1:0]        r_res_col, n_res_col;
    logic [OFFSET_WIDTH-1:0] r_res_ls, n_res_ls;
    logic                    r_res_virt, n_res_virt;
    logic [1:0]              r_res_st, n_res_st;

    logic                    r_o_valid, n_o_valid;
    logic [LINE_W-1:0]       r_o_bl;
    logic [LINE_W-1:0]       r_o_el;
    logic [COL_W-1:0]        r_o_col;
    logic [OFFSET_WIDTH-1:0] r_o_ls;
    logic                    r_o_virt;
    logic [1:0]              r_o_st;

    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [IDX_W-1:0]        raddr;
    logic [LINE_W:0]         mid_sum;
    logic [LINE_W-1:0]       mid_full;
    logic [LINE_W-1:0]       line_m1;
    logic [LINE_W-1:0]       b_m1;
    logic [OFFSET_WIDTH-1:0] rd_val;
    logic [OFFSET_WIDTH-1:0] col_base;
    logic                    out_free;
    logic                    load_out;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_full = mid_sum[LINE_W:1];
    assign line_m1  = i_line_number - LINE_W'(1);
    assign b_m1     = r_b - LINE_W'(1);
    assign rd_val   = r_rzero ? '0 : r_rdata;
    assign col_base = (r_res_bl == '0) ? '0 : rd_val;
    assign out_free = !r_o_valid || !i_stall;
    assign load_out = (r_state == S_RES) && out_free;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_phase    = r_phase;
        n_b        = r_b;
        n_x        = r_x;
        n_beg      = r_beg;
        n_end      = r_end;
        n_res_bl   = r_res_bl;
        n_res_el   = r_res_el;
        n_res_col  = r_res_col;
        n_res_ls   = r_res_ls;
        n_res_virt = r_res_virt;
        n_res_st   = r_res_st;
        o_q_pop    = 1'b0;
        we         = 1'b0;
        waddr      = r_count[IDX_W-1:0];
        raddr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop    = 1'b1;
                    n_res_bl   = '0;
                    n_res_el   = '0;
                    n_res_col  = '0;
                    n_res_ls   = '0;
                    n_res_virt = 1'b0;
                    n_res_st   = ST_OK;
                    n_state    = S_RES;
                    unique case (i_ctl.op)
                        OP_APPEND: begin
                            if (r_count >= LINE_W'(TABLE_DEPTH)) begin
                                n_res_st = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + LINE_W'(1);
                            end
                        end
                        OP_LOOKUP: begin
                            n_res_st = i_ctl.status;
                            if (!i_ctl.skip) begin
                                n_x     = i_begin_index;
                                n_beg   = i_begin_index;
                                n_end   = i_end_index;
                                n_lo    = '0;
                                n_hi    = r_count;
                                n_phase = 1'b0;
                                n_state = S_SRD;
                            end
                        end
                        OP_LINE: begin
                            if (i_line_number == '0 || i_line_number > r_count) begin
                                n_res_st = ST_BAD_LINE;
                            end else begin
                                raddr   = line_m1[IDX_W-1:0];
                                n_state = S_LWT;
                            end
                        end
                        OP_VIRT: begin
                            n_res_virt = (i_line_number == '0) || (i_line_number >= r_count);
                        end
                        default: begin
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_SRD: begin
                if (r_lo < r_hi) begin
                    raddr   = mid_full[IDX_W-1:0];
                    n_mid   = mid_full[IDX_W-1:0];
                    n_state = S_SCMP;
                end else if (!r_phase) begin
                    n_b     = r_lo;
                    n_x     = r_end;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_phase = 1'b1;
                end else begin
                    n_res_bl = r_b;
                    n_res_el = r_lo;
                    raddr    = b_m1[IDX_W-1:0];
                    n_state  = S_CWT;
                end
            end
            S_SCMP: begin
                if (rd_val <= r_x) begin
                    n_lo = LINE_W'(r_mid) + LINE_W'(1);
                end else begin
                    n_hi = LINE_W'(r_mid);
                end
                n_state = S_SRD;
            end
            S_CWT: begin
                n_res_col = COL_W'(r_beg) - COL_W'(col_base) + COL_W'(1);
                n_state   = S_RES;
            end
            S_LWT: begin
                n_res_ls = rd_val;
                n_state  = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (load_out) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= LINE_W'(1);
            r_o_valid <= 1'b0;
            r_phase   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
            r_phase   <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_b        <= n_b;
        r_x        <= n_x;
        r_beg      <= n_beg;
        r_end      <= n_end;
        r_res_bl   <= n_res_bl;
        r_res_el   <= n_res_el;
        r_res_col  <= n_res_col;
        r_res_ls   <= n_res_ls;
        r_res_virt <= n_res_virt;
        r_res_st   <= n_res_st;
        if (load_out) begin
            r_o_bl   <= r_res_bl;
            r_o_el   <= r_res_el;
            r_o_col  <= r_res_col;
            r_o_ls   <= r_res_ls;
            r_o_virt <= r_res_virt;
            r_o_st   <= r_res_st;
        end
    end

    // Entry 0 is never written; reads of it return zero
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= i_start_index;
        end
        r_rdata <= r_mem[raddr];
        r_rzero <= (raddr == '0);
    end

    assign o_valid        = r_o_valid;
    assign o_begin_line   = r_o_bl;
    assign o_end_line     = r_o_el;
    assign o_begin_column = r_o_col;
    assign o_line_start   = r_o_ls;
    assign o_is_virtual   = r_o_virt;
    assign o_status       = r_o_st;

endmodule

[hw/rtl/line_start_table_lookup.sv]
// A lookup runs two upper-bound searches of k search steps each
// (at most ceil(log2(entries+1))) on the one table read port. The back end takes a
// new word only once it is done with the last one; the queue holds two more words,
// the output one.
// Synchronous active-low reset: entry count 1, limit all ones, queue and output empty.
// The table is not cleared; entry 0 reads as zero. Depends on lst_pkg and the sub-blocks.
module line_start_table_lookup #(
    parameter int TABLE_DEPTH  = lst_pkg::DEF_TABLE_DEPTH,
    parameter int OFFSET_WIDTH = lst_pkg::DEF_OFFSET_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_operation,
    input  logic [OFFSET_WIDTH-1:0]         i_start_index,
    input  logic [OFFSET_WIDTH-1:0]         i_begin_index,
    input  logic [OFFSET_WIDTH-1:0]         i_end_index,
    input  logic [$clog2(TABLE_DEPTH):0]    i_line_number,
    input  logic                            i_cfg_we,
    input  logic [lst_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [$clog2(TABLE_DEPTH):0]    o_begin_line,
    output logic [$clog2(TABLE_DEPTH):0]    o_end_line,
    output logic [OFFSET_WIDTH:0]           o_begin_column,
    output logic [OFFSET_WIDTH-1:0]         o_line_start,
    output logic                            o_is_virtual,
    output logic [1:0]                      o_status
);
    import lst_pkg::*;

    localparam int LINE_W = $clog2(TABLE_DEPTH) + 1;
    localparam int QW     = CTL_W + 3 * OFFSET_WIDTH + LINE_W;

    t_ctl          f_ctl;
    t_ctl          q_ctl;
    logic          f_push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_out;

    lst_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_begin_index (i_begin_index),
        .i_end_index   (i_end_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_full      (q_full),
        .o_push        (f_push),
        .o_ctl         (f_ctl)
    );

    assign q_in = {f_ctl, i_start_index, i_begin_index, i_end_index, i_line_number};

    lst_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_word  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_word  (q_out)
    );

    assign q_ctl = t_ctl'(q_out[QW-1 -: CTL_W]);

    lst_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_ctl          (q_ctl),
        .i_start_index  (q_out[3*OFFSET_WIDTH+LINE_W-1 -: OFFSET_WIDTH]),
        .i_begin_index  (q_out[2*OFFSET_WIDTH+LINE_W-1 -: OFFSET_WIDTH]),
        .i_end_index    (q_out[OFFSET_WIDTH+LINE_W-1 -: OFFSET_WIDTH]),
        .i_line_number  (q_out[LINE_W-1:0]),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_begin_line   (o_begin_line),
        .o_end_line     (o_end_line),
        .o_begin_column (o_begin_column),
        .o_line_start   (o_line_start),
        .o_is_virtual   (o_is_virtual),
        .o_status       (o_status)
    );

endmodule

[hw/rtl/lst_checker.sv]
// Port-level checks for the line start table lookup, bound to the top level.
// Depends on lst_pkg and line_start_table_lookup_macros.svh.
`include "line_start_table_lookup_macros.svh"

module lst_checker #(
    parameter int TABLE_DEPTH  = lst_pkg::DEF_TABLE_DEPTH,
    parameter int OFFSET_WIDTH = lst_pkg::DEF_OFFSET_WIDTH
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic [1:0]                      i_operation,
    input logic [OFFSET_WIDTH-1:0]         i_start_index,
    input logic [OFFSET_WIDTH-1:0]         i_begin_index,
    input logic [OFFSET_WIDTH-1:0]         i_end_index,
    input logic [$clog2(TABLE_DEPTH):0]    i_line_number,
    input logic                            i_cfg_we,
    input logic [lst_pkg::CFG_W-1:0]       i_cfg_wdata,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [$clog2(TABLE_DEPTH):0]    o_begin_line,
    input logic [$clog2(TABLE_DEPTH):0]    o_end_line,
    input logic [OFFSET_WIDTH:0]           o_begin_column,
    input logic [OFFSET_WIDTH-1:0]         o_line_start,
    input logic                            o_is_virtual,
    input logic [1:0]                      o_status
);
    import lst_pkg::*;

    `LST_ASSERT_NXT(a_hold_valid, o_valid && i_stall, o_valid,
        "result word dropped while stalled")

    `LST_ASSERT_IMP(a_range_zero, o_valid && o_status == ST_RANGE,
        o_begin_line == '0 && o_end_line == '0 && o_begin_column == '0
            && o_line_start == '0 && !o_is_virtual,
        "range error with non-zero fields")

    `LST_ASSERT_IMP(a_no_loc, o_valid && o_status == ST_OK && o_begin_line == '0,
        o_end_line == '0 && o_begin_column == '0,
        "end line or column set without begin line")

    `LST_ASSERT_IMP(a_query_excl, o_valid && (o_is_virtual || o_line_start != '0),
        o_status == ST_OK && o_begin_line == '0 && o_end_line == '0,
        "query result mixed with lookup fields")

endmodule

bind line_start_table_lookup lst_checker #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
) u_lst_checker (.*);
